FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/foaf_pkg.sv
// ----------------------------------------------------------------------------
// foaf_pkg
// Types, command and decision codes, and default sizes of the open filter.
// ----------------------------------------------------------------------------
package foaf_pkg;

    localparam int GROUP_SLOTS_DEF  = 16;
    localparam int TABLE_SLOTS_DEF  = 8;
    localparam int PREFIX_BYTES_DEF = 128;
    localparam int PATH_BYTES_DEF   = 256;

    typedef enum logic [2:0] {
        CMD_WRITE_GROUP  = 3'd0,
        CMD_WRITE_INODE  = 3'd1,
        CMD_WRITE_PREFIX = 3'd2,
        CMD_OPEN         = 3'd3,
        CMD_PATH_CHAR    = 3'd4,
        CMD_PATH_FAIL    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        DEC_ALLOW_UNWATCHED = 2'd0,
        DEC_ALLOW           = 2'd1,
        DEC_BLOCK_INODE     = 2'd2,
        DEC_BLOCK_PREFIX    = 2'd3
    } dec_t;

endpackage

FILE: rtl/foaf_ram.sv
// ----------------------------------------------------------------------------
// foaf_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module foaf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a_reg <= mem_reg[rd_addr_a];
        rd_data_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

FILE: rtl/file_open_access_filter.sv
// ----------------------------------------------------------------------------
// file_open_access_filter
// Decides per open request: allow unwatched group, block by inode, block by
// path prefix, or allow. Tables are loaded by write items.
// ----------------------------------------------------------------------------
//
//  channel   handshake          fields
//  --------  -----------------  -----------------------------------------------
//  item in   start / busy       command slot entry_valid group_id device
//                               inode_number byte_index character last_char
//  result    done (1 cycle)     decision matched_prefix
//
//  - One item per cycle while busy is low: accepted into the input register,
//    evaluated from it, result registered; done comes from the result register.
//  - The prefix RAM read (one row per slot RAM, two ports) is issued at accept.
//  - After reset the prefix RAMs are zeroed one byte row a cycle, with busy
//    high until every row is cleared; then the block is ready.
//  - Results cannot be stalled; done marks a valid result for one cycle.
//
`include "assert_macros.svh"

module file_open_access_filter #(
    parameter int GROUP_SLOTS  = foaf_pkg::GROUP_SLOTS_DEF,
    parameter int TABLE_SLOTS  = foaf_pkg::TABLE_SLOTS_DEF,
    parameter int PREFIX_BYTES = foaf_pkg::PREFIX_BYTES_DEF,
    parameter int PATH_BYTES   = foaf_pkg::PATH_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [3:0]  slot,
    input  logic        entry_valid,
    input  logic [63:0] group_id,
    input  logic [31:0] device,
    input  logic [63:0] inode_number,
    input  logic [6:0]  byte_index,
    input  logic [7:0]  character,
    input  logic        last_char,
    output logic        done,
    output logic [1:0]  decision,
    output logic [2:0]  matched_prefix
);

    localparam int AW = $clog2(PREFIX_BYTES);   // prefix byte address
    localparam int PW = $clog2(PATH_BYTES);     // path position

    // ------------------------------------------------------------------
    // Tables (written at the accept edge of write items)
    // ------------------------------------------------------------------
    logic [GROUP_SLOTS-1:0] group_valid_reg;
    logic [63:0]            group_table_reg [GROUP_SLOTS];
    logic [TABLE_SLOTS-1:0] inode_valid_reg;
    logic [31:0]            inode_device_reg [TABLE_SLOTS];
    logic [63:0]            inode_number_reg [TABLE_SLOTS];

    // Reset clearing pass over the prefix RAMs
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Issue-side path position, drives the RAM read addresses
    logic [PW-1:0] issue_pos_reg;

    // Input register (stage 1)
    logic        s1_valid_reg;
    logic [2:0]  s1_cmd_reg;
    logic [63:0] s1_group_reg;
    logic [31:0] s1_device_reg;
    logic [63:0] s1_inode_reg;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic        s1_in_range_reg;   // next byte position lies inside a prefix
    logic        s1_overflow_reg;   // no room for the terminator

    // Path match state
    logic                   awaiting_reg, awaiting_next;
    logic [TABLE_SLOTS-1:0] alive_reg, alive_next;
    logic [TABLE_SLOTS-1:0] matched_reg, matched_next;

    // Result register
    logic       done_reg, done_next;
    logic [1:0] decision_reg, decision_next;
    logic [2:0] match_idx_reg, match_idx_next;

    logic accept;
    logic bi_ok;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd_cur  [TABLE_SLOTS];   // prefix byte at position p
    logic [7:0]    rd_next [TABLE_SLOTS];   // prefix byte at position p+1

    assign busy   = clr_active_reg;
    assign accept = start && !busy;
    assign bi_ok  = (32'(byte_index) < PREFIX_BYTES);

    // ------------------------------------------------------------------
    // Group and inode tables
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_valid_reg <= '0;
            inode_valid_reg <= '0;
        end
        else if (accept)
        begin
            for (int g = 0; g < GROUP_SLOTS; g++)
            begin
                if (command == foaf_pkg::CMD_WRITE_GROUP && 32'(slot) == g)
                begin
                    group_valid_reg[g] <= entry_valid;
                end
            end
            for (int k = 0; k < TABLE_SLOTS; k++)
            begin
                if (command == foaf_pkg::CMD_WRITE_INODE && 32'(slot) == k)
                begin
                    inode_valid_reg[k] <= entry_valid;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int g = 0; g < GROUP_SLOTS; g++)
            begin
                if (command == foaf_pkg::CMD_WRITE_GROUP && 32'(slot) == g)
                begin
                    group_table_reg[g] <= group_id;
                end
            end
            for (int k = 0; k < TABLE_SLOTS; k++)
            begin
                if (command == foaf_pkg::CMD_WRITE_INODE && 32'(slot) == k)
                begin
                    inode_device_reg[k] <= device;
                    inode_number_reg[k] <= inode_number;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Prefix RAMs: one per slot, addressed by byte position
    // ------------------------------------------------------------------
    assign wr_addr   = clr_active_reg ? clr_addr_reg : AW'(byte_index);
    assign wr_data   = clr_active_reg ? 8'd0 : character;
    // an open needs byte 0 of every prefix; a path byte needs p and p+1
    assign rd_addr_a = (command == foaf_pkg::CMD_OPEN) ? '0 : AW'(issue_pos_reg);
    assign rd_addr_b = AW'(issue_pos_reg + PW'(1));

    for (genvar k = 0; k < TABLE_SLOTS; k++)
    begin : g_prefix
        logic wr_en;
        assign wr_en = clr_active_reg ||
                       (accept && command == foaf_pkg::CMD_WRITE_PREFIX &&
                        32'(slot) == k && bi_ok);

        foaf_ram #(
            .WIDTH (8),
            .DEPTH (PREFIX_BYTES),
            .AW    (AW)
        ) u_ram (
            .clk       (clk),
            .wr_en     (wr_en),
            .wr_addr   (wr_addr),
            .wr_data   (wr_data),
            .rd_addr_a (rd_addr_a),
            .rd_addr_b (rd_addr_b),
            .rd_data_a (rd_cur[k]),
            .rd_data_b (rd_next[k])
        );
    end

    // Clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(PREFIX_BYTES - 1))
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    // Issue position: restarts on an open, steps per path byte and saturates
    // where the terminator no longer fits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_pos_reg <= '0;
        end
        else if (accept)
        begin
            if (command == foaf_pkg::CMD_OPEN)
            begin
                issue_pos_reg <= '0;
            end
            else if (command == foaf_pkg::CMD_PATH_CHAR &&
                     32'(issue_pos_reg) < PATH_BYTES - 1)
            begin
                issue_pos_reg <= issue_pos_reg + PW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg      <= command;
            s1_group_reg    <= group_id;
            s1_device_reg   <= device;
            s1_inode_reg    <= inode_number;
            s1_char_reg     <= character;
            s1_last_reg     <= last_char;
            s1_in_range_reg <= (32'(issue_pos_reg) + 1 < PREFIX_BYTES);
            s1_overflow_reg <= (32'(issue_pos_reg) >= PATH_BYTES - 1);
        end
    end

    // ------------------------------------------------------------------
    // Evaluation
    // ------------------------------------------------------------------
    always_comb
    begin
        logic                   watched;
        logic                   inode_hit;
        logic [TABLE_SLOTS-1:0] upd_alive;
        logic [TABLE_SLOTS-1:0] upd_matched;
        logic [2:0]             low_idx;

        watched = 1'b0;
        for (int g = 0; g < GROUP_SLOTS; g++)
        begin
            if (group_valid_reg[g] && group_table_reg[g] == s1_group_reg)
            begin
                watched = 1'b1;
            end
        end

        inode_hit = 1'b0;
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            if (inode_valid_reg[k] && inode_device_reg[k] == s1_device_reg &&
                inode_number_reg[k] == s1_inode_reg)
            begin
                inode_hit = 1'b1;
            end
        end

        // per-prefix step for one path byte
        upd_alive   = alive_reg;
        upd_matched = matched_reg;
        if (s1_overflow_reg)
        begin
            upd_alive   = '0;
            upd_matched = '0;
        end
        else
        begin
            for (int k = 0; k < TABLE_SLOTS; k++)
            begin
                if (alive_reg[k])
                begin
                    if (!s1_in_range_reg || rd_cur[k] != s1_char_reg)
                    begin
                        upd_alive[k] = 1'b0;
                    end
                    else if (rd_next[k] == 8'd0)
                    begin
                        upd_alive[k]   = 1'b0;
                        upd_matched[k] = 1'b1;
                    end
                end
            end
        end

        // lowest matching prefix
        low_idx = '0;
        for (int k = TABLE_SLOTS - 1; k >= 0; k--)
        begin
            if (upd_matched[k])
            begin
                low_idx = 3'(k);
            end
        end

        awaiting_next  = awaiting_reg;
        alive_next     = alive_reg;
        matched_next   = matched_reg;
        done_next      = 1'b0;
        decision_next  = decision_reg;
        match_idx_next = match_idx_reg;

        if (s1_valid_reg)
        begin
            case (s1_cmd_reg)
                foaf_pkg::CMD_OPEN:
                begin
                    // a pending request is dropped silently
                    awaiting_next = 1'b0;
                    if (!watched)
                    begin
                        done_next      = 1'b1;
                        decision_next  = foaf_pkg::DEC_ALLOW_UNWATCHED;
                        match_idx_next = '0;
                    end
                    else if (inode_hit)
                    begin
                        done_next      = 1'b1;
                        decision_next  = foaf_pkg::DEC_BLOCK_INODE;
                        match_idx_next = '0;
                    end
                    else
                    begin
                        awaiting_next = 1'b1;
                        matched_next  = '0;
                        for (int k = 0; k < TABLE_SLOTS; k++)
                        begin
                            // empty prefixes never take part
                            alive_next[k] = (rd_cur[k] != 8'd0);
                        end
                    end
                end
                foaf_pkg::CMD_PATH_CHAR:
                begin
                    if (awaiting_reg)
                    begin
                        alive_next   = upd_alive;
                        matched_next = upd_matched;
                        if (s1_last_reg)
                        begin
                            awaiting_next = 1'b0;
                            done_next     = 1'b1;
                            if (|upd_matched)
                            begin
                                decision_next  = foaf_pkg::DEC_BLOCK_PREFIX;
                                match_idx_next = low_idx;
                            end
                            else
                            begin
                                decision_next  = foaf_pkg::DEC_ALLOW;
                                match_idx_next = '0;
                            end
                        end
                    end
                end
                foaf_pkg::CMD_PATH_FAIL:
                begin
                    if (awaiting_reg)
                    begin
                        awaiting_next  = 1'b0;
                        done_next      = 1'b1;
                        decision_next  = foaf_pkg::DEC_ALLOW;
                        match_idx_next = '0;
                    end
                end
                default:
                begin
                    // table writes were done at accept; other codes do nothing
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg <= 1'b0;
            alive_reg    <= '0;
            matched_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            awaiting_reg <= awaiting_next;
            alive_reg    <= alive_next;
            matched_reg  <= matched_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        decision_reg  <= decision_next;
        match_idx_reg <= match_idx_next;
    end

    assign done           = done_reg;
    assign decision       = decision_reg;
    assign matched_prefix = match_idx_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_IMPLIES(a_no_item_in_clear, clk, rst_n, clr_active_reg, !s1_valid_reg, "item taken during prefix clear")
    `ASSERT_NEXT(a_result_needs_item, clk, rst_n, !s1_valid_reg, !done_reg, "result without an evaluated item")
    `ASSERT_IMPLIES(a_idx_only_on_prefix, clk, rst_n, done_reg && decision_reg != foaf_pkg::DEC_BLOCK_PREFIX, match_idx_reg == 3'd0, "prefix index set on a non-prefix decision")
    `ASSERT_IMPLIES(a_alive_matched_apart, clk, rst_n, 1'b1, (alive_reg & matched_reg) == '0, "prefix both alive and matched")

endmodule
